>>> hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the lambda adaptation freeze block.
// No dependencies; with SYNTH defined the macros expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> hw/rtl/lafz_pkg.sv
// Types and constants of the lambda adaptation freeze block.
// No dependencies; used by all RTL modules of the block.
package lafz_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FILTER_GAIN     = 2'd0;
    localparam logic [1:0] CFG_DELAY_RELOAD    = 2'd1;
    localparam logic [1:0] CFG_ERROR_THRESHOLD = 2'd2;

    // Configuration reset values.
    localparam logic [7:0]  GAIN_RESET      = 8'd16;
    localparam logic [7:0]  RELOAD_RESET    = 8'd50;
    localparam logic [15:0] THRESHOLD_RESET = 16'd128;

    // Upper bound of the delay counter.
    localparam logic [7:0] DELAY_CAP = 8'd200;

    // Widths of the stream payloads.
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 64;

    typedef struct packed {
        logic               adapt_request;
        logic               monitor_in_range;
        logic               max_updated;
        logic               min_updated;
        logic signed [15:0] feedback_max;
        logic signed [15:0] feedback_min;
    } lafz_item_t;

    // Mean and filter results of one item.
    typedef struct packed {
        logic signed [15:0] mean;
        logic signed [15:0] filtered;
    } lafz_filt_t;

    // Delay, latch and clear results of one item.
    typedef struct packed {
        logic [7:0]         delay;
        logic               freeze;
        logic signed [15:0] adapted;
        logic               clear;
    } lafz_ctl_t;

endpackage

>>> hw/rtl/lafz_mean_filter.sv
// Mean of the tracked feedback extremes and the first-order low-pass filter.
// Depends on lafz_pkg.
module lafz_mean_filter (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  lafz_pkg::lafz_item_t item,
    input  logic [7:0]           gain,
    output lafz_pkg::lafz_filt_t res
);

    logic signed [15:0] mean_hold_reg;
    logic signed [23:0] filter_memory_reg;
    logic               reseed_pending_reg;
    logic               mean_valid_prev_reg;

    logic               det;
    logic signed [16:0] sum;
    logic signed [16:0] sum_adj;
    logic signed [15:0] mean_next;
    logic               reseed;
    logic signed [23:0] target;
    logic signed [24:0] diff;
    logic signed [33:0] prod;
    logic signed [25:0] mem_step;
    logic signed [23:0] mem_next;

    always_comb
    begin
        det = item.max_updated & item.min_updated;
        // Halve with truncation toward zero: a negative odd sum is bumped up first.
        sum       = {item.feedback_max[15], item.feedback_max}
                  + {item.feedback_min[15], item.feedback_min};
        sum_adj   = sum + {16'd0, sum[16] & sum[0]};
        mean_next = det ? sum_adj[16:1] : mean_hold_reg;

        reseed = reseed_pending_reg | (~mean_valid_prev_reg & det);
        target = {mean_next, 8'd0};
        diff   = {target[23], target} - {filter_memory_reg[23], filter_memory_reg};
        prod   = $signed({1'b0, gain}) * diff;
        // The step never overshoots the target, so the sum fits back in 24 bits.
        mem_step = {{2{filter_memory_reg[23]}}, filter_memory_reg} + prod[33:8];
        mem_next = reseed ? target : mem_step[23:0];

        res.mean     = mean_next;
        res.filtered = mem_next[23:8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_hold_reg       <= '0;
            filter_memory_reg   <= '0;
            reseed_pending_reg  <= 1'b1;
            mean_valid_prev_reg <= 1'b0;
        end
        else if (step)
        begin
            mean_hold_reg       <= mean_next;
            filter_memory_reg   <= mem_next;
            reseed_pending_reg  <= 1'b0;
            mean_valid_prev_reg <= det;
        end
    end

endmodule

>>> hw/rtl/lafz_freeze_ctrl.sv
// Delay counter, freeze latch, adapted value capture and min/max clear request.
// Depends on lafz_pkg.
module lafz_freeze_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  lafz_pkg::lafz_item_t item,
    input  lafz_pkg::lafz_filt_t filt,
    input  logic [7:0]           reload,
    input  logic [15:0]          threshold,
    output lafz_pkg::lafz_ctl_t  ctl
);

    logic               in_range_prev_reg;
    logic               request_prev_reg;
    logic [7:0]         delay_count_reg;
    logic               freeze_latch_reg;
    logic signed [15:0] adapted_hold_reg;

    logic               run;
    logic [7:0]         delay_dec;
    logic [7:0]         delay_raw;
    logic [7:0]         delay_next;
    logic signed [16:0] err;
    logic [16:0]        err_abs;
    logic               latch_clr;
    logic               freeze_next;
    logic signed [15:0] adapted_next;

    always_comb
    begin
        run        = item.adapt_request & (item.monitor_in_range | ~in_range_prev_reg);
        delay_dec  = (delay_count_reg == 8'd0) ? 8'd0 : delay_count_reg - 8'd1;
        delay_raw  = run ? delay_dec : reload;
        delay_next = (delay_raw > lafz_pkg::DELAY_CAP) ? lafz_pkg::DELAY_CAP : delay_raw;

        err     = {filt.mean[15], filt.mean} - {filt.filtered[15], filt.filtered};
        err_abs = err[16] ? -err : err;

        // Reset side of the latch wins over the set side.
        latch_clr   = ~item.adapt_request | (in_range_prev_reg & ~item.monitor_in_range);
        freeze_next = ~latch_clr & (freeze_latch_reg
                    | ((err_abs[15:0] <= threshold) & (delay_next == 8'd0)));

        adapted_next = (freeze_next & ~freeze_latch_reg) ? filt.filtered : adapted_hold_reg;

        ctl.delay   = delay_next;
        ctl.freeze  = freeze_next;
        ctl.adapted = adapted_next;
        ctl.clear   = (item.adapt_request & ~request_prev_reg)
                    | (~item.monitor_in_range & in_range_prev_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_range_prev_reg <= 1'b0;
            request_prev_reg  <= 1'b0;
            delay_count_reg   <= '0;
            freeze_latch_reg  <= 1'b0;
            adapted_hold_reg  <= '0;
        end
        else if (step)
        begin
            in_range_prev_reg <= item.monitor_in_range;
            request_prev_reg  <= item.adapt_request;
            delay_count_reg   <= delay_next;
            freeze_latch_reg  <= freeze_next;
            adapted_hold_reg  <= adapted_next;
        end
    end

endmodule

>>> hw/rtl/lambda_adaptation_freeze.sv
// Lambda adaptation freeze block: top level with stream ports and configuration registers.
// Depends on lafz_pkg, lafz_mean_filter, lafz_freeze_ctrl and assert_macros.svh.
//
// Usage: one input item is sent per control tick on the s_* channel and yields exactly
// one result item on the m_* channel. An item holds the adapt request, the in-range flag,
// the two update flags and the tracked feedback maximum and minimum. The result holds the
// held mean, the filtered mean, the delay counter, the freeze latch, the adapted value
// and the pulse that asks for the min/max trackers to be cleared.
// Path: an item accepted at a clock edge sits in the input register; its result is loaded
// into the output register, which drives m_tvalid, once that register is free or emptied.
// Throughput: one item per cycle while m_tready is high. The mean, the filter multiply (8
// by 25 bits) and the error compare form the single combinational path between registers.
// Stalls: while m_tready is low the result waits in the output register and one more item
// is still taken into the input register; only then does s_tready fall.
// Configuration: cfg_index selects filter_gain (0), delay_reload (1) or error_threshold (2);
// cfg_ready is always high and other indexes are ignored. Writes are meant for idle time.
// Reset: rst_n clears both registers' valid flags, restores the register defaults (16, 50,
// 128) and arms the filter to reseed from the mean on the first item.
`include "assert_macros.svh"

module lambda_adaptation_freeze (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input item stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [0] adapt_request, [1] monitor_in_range, [2] max_updated, [3] min_updated,
    // [19:4] feedback_max, [35:20] feedback_min, [39:36] zero.
    input  logic [lafz_pkg::IN_DATA_W-1:0]    s_tdata,
    // Result item stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [15:0] mean_out, [31:16] filtered_out, [39:32] delay_out, [40] freeze_out,
    // [56:41] adapted_out, [57] clear_minmax, [63:58] zero.
    output logic [lafz_pkg::OUT_DATA_W-1:0]   m_tdata,
    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [15:0]                       cfg_data
);

    logic                 in_valid_reg;
    logic                 in_valid_next;
    lafz_pkg::lafz_item_t in_data_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    lafz_pkg::lafz_filt_t out_filt_reg;
    lafz_pkg::lafz_ctl_t  out_ctl_reg;

    logic [7:0]           gain_reg;
    logic [7:0]           reload_reg;
    logic [15:0]          threshold_reg;

    logic                 fire;
    logic                 in_take;
    lafz_pkg::lafz_filt_t filt;
    lafz_pkg::lafz_ctl_t  ctl;

    // An item in the input register moves on whenever the output register is free or
    // is being emptied in the same cycle; all state advances exactly at that edge.
    assign fire      = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready  = ~in_valid_reg | fire;
    assign in_take   = s_tvalid & s_tready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        in_valid_next = in_take ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
        out_valid_next = fire ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg.adapt_request    <= s_tdata[0];
            in_data_reg.monitor_in_range <= s_tdata[1];
            in_data_reg.max_updated      <= s_tdata[2];
            in_data_reg.min_updated      <= s_tdata[3];
            in_data_reg.feedback_max     <= s_tdata[19:4];
            in_data_reg.feedback_min     <= s_tdata[35:20];
        end
        if (fire)
        begin
            out_filt_reg <= filt;
            out_ctl_reg  <= ctl;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= lafz_pkg::GAIN_RESET;
            reload_reg    <= lafz_pkg::RELOAD_RESET;
            threshold_reg <= lafz_pkg::THRESHOLD_RESET;
        end
        else if (cfg_valid & cfg_ready)
        begin
            case (cfg_index)
                lafz_pkg::CFG_FILTER_GAIN:     gain_reg      <= cfg_data[7:0];
                lafz_pkg::CFG_DELAY_RELOAD:    reload_reg    <= cfg_data[7:0];
                lafz_pkg::CFG_ERROR_THRESHOLD: threshold_reg <= cfg_data;
                default:                       ;
            endcase
        end
    end

    lafz_mean_filter u_mean_filter (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (fire),
        .item  (in_data_reg),
        .gain  (gain_reg),
        .res   (filt)
    );

    lafz_freeze_ctrl u_freeze_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (fire),
        .item      (in_data_reg),
        .filt      (filt),
        .reload    (reload_reg),
        .threshold (threshold_reg),
        .ctl       (ctl)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0,
                       out_ctl_reg.clear,
                       out_ctl_reg.adapted,
                       out_ctl_reg.freeze,
                       out_ctl_reg.delay,
                       out_filt_reg.filtered,
                       out_filt_reg.mean};

    // A fired item always shows up as a result in the next cycle.
    `ASSERT_NEXT(a_fire_shows_result, clk, rst_n, fire, m_tvalid, "fired item has no result")
    // The input side only stalls when both registers are full and the receiver stalls.
    `ASSERT_IMPLIES(a_ready_only_when_blocked, clk, rst_n, !s_tready, in_valid_reg && m_tvalid && !m_tready, "input stalled without backpressure")
    // The delay counter never leaves its capped range.
    `ASSERT_IMPLIES(a_delay_capped, clk, rst_n, m_tvalid, out_ctl_reg.delay <= lafz_pkg::DELAY_CAP, "delay counter above cap")
    // Without an adapt request the freeze latch is cleared.
    `ASSERT_NEXT(a_freeze_needs_request, clk, rst_n, fire && !in_data_reg.adapt_request, !out_ctl_reg.freeze, "freeze set without request")

endmodule

>>> test/tb.sv
// Self-checking testbench for the lambda adaptation freeze block.
// Depends on lafz_pkg and lambda_adaptation_freeze; needs no other files.
// Items go through stream ports, and an in-bench predictor checks every result field.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lafz_pkg::*;

    // Result item as it sits in m_tdata, lowest field in the lowest bits.
    typedef struct packed {
        logic               clear;
        logic signed [15:0] adapted;
        logic               freeze;
        logic [7:0]         delay;
        logic signed [15:0] filtered;
        logic signed [15:0] mean;
    } res_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

    // One row of the directed table: either an item or a register setting.
    typedef struct {
        row_kind_e   kind;
        lafz_item_t  it;
        bit          typed;
        res_t        res;
        logic [7:0]  gain;
        logic [7:0]  reload;
        logic [15:0] thr;
    } dir_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [1:0]            cfg_index;
    logic [15:0]           cfg_data;

    // Predictor state: the block's registers as this bench believes them to be.
    logic signed [15:0] hold_mean    = '0;
    int                 flt_mem      = 0;
    logic signed [15:0] flt_out      = '0;
    bit                 reseed_armed = 1'b1;
    bit                 both_prev    = 1'b0;
    bit                 inr_prev     = 1'b0;
    bit                 req_prev     = 1'b0;
    logic [7:0]         dly_cnt      = '0;
    bit                 frozen       = 1'b0;
    logic signed [15:0] adapt_val    = '0;
    logic [7:0]         gain_reg     = GAIN_RESET;
    logic [7:0]         reload_reg   = RELOAD_RESET;
    logic [15:0]        thr_reg      = THRESHOLD_RESET;

    res_t pending_results[$];
    int   mismatches = 0;

    // Handshake between the stimulus and the result side.
    bit hold_req = 1'b0;
    bit calm     = 1'b0;

    // Slowly varying levels that shape the well-formed random sequences.
    bit req_lvl = 1'b0;
    bit inr_lvl = 1'b0;
    int center  = 0;

    dir_row_t dir_tab[$];

    lambda_adaptation_freeze dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Advances the predictor by one accepted item and returns the result it should produce.
    function automatic res_t predict_tick(input lafz_item_t it);
        res_t       r;
        bit         both;
        bit         clr;
        bit         was_frozen;
        int         sum;
        int         err;
        longint     diff;
        longint     mem;
        logic [7:0] dly;
        both = it.max_updated && it.min_updated;
        clr = (it.adapt_request && !req_prev) || (!it.monitor_in_range && inr_prev);
        was_frozen = frozen;

        // Mean of the extremes, rounded toward zero, held until both flags are set again.
        if (both)
        begin
            sum = int'(it.feedback_max) + int'(it.feedback_min);
            hold_mean = 16'(sum / 2);
        end

        // The filter restarts from the mean after reset and when the mean becomes valid.
        if (reseed_armed || (!both_prev && both))
        begin
            flt_out = hold_mean;
            flt_mem = int'(hold_mean) * 256;
            reseed_armed = 1'b0;
        end
        else
        begin
            diff = longint'(hold_mean) * 256 - longint'(flt_mem);
            mem = longint'(flt_mem) + ((longint'(gain_reg) * diff) >>> 8);
            flt_mem = int'(mem);
            flt_out = 16'(mem >>> 8);
        end

        // Delay counts down while requested, unless the monitor has just left its range; otherwise it reloads.
        if (it.adapt_request && (it.monitor_in_range || !inr_prev))
            dly = (dly_cnt != 8'd0) ? dly_cnt - 8'd1 : 8'd0;
        else
            dly = reload_reg;
        dly_cnt = (dly > DELAY_CAP) ? DELAY_CAP : dly;

        // Reset side of the latch wins over its set side.
        if (!it.adapt_request || (inr_prev && !it.monitor_in_range))
            frozen = 1'b0;
        else
        begin
            err = int'(hold_mean) - int'(flt_out);
            if (err < 0)
                err = -err;
            if (err <= int'(thr_reg) && dly_cnt == 8'd0)
                frozen = 1'b1;
        end

        if (frozen && !was_frozen)
            adapt_val = flt_out;

        both_prev = both;
        inr_prev = it.monitor_in_range;
        req_prev = it.adapt_request;

        r.mean = hold_mean;
        r.filtered = flt_out;
        r.delay = dly_cnt;
        r.freeze = frozen;
        r.adapted = adapt_val;
        r.clear = clr;
        return r;
    endfunction

    function automatic dir_row_t row_item(input bit req, input bit inr, input bit mxu,
                                          input bit mnu, input int fmax, input int fmin);
        dir_row_t r;
        r.kind = ROW_ITEM;
        r.it.adapt_request = req;
        r.it.monitor_in_range = inr;
        r.it.max_updated = mxu;
        r.it.min_updated = mnu;
        r.it.feedback_max = 16'(fmax);
        r.it.feedback_min = 16'(fmin);
        r.typed = 1'b0;
        r.res = '0;
        r.gain = '0;
        r.reload = '0;
        r.thr = '0;
        return r;
    endfunction

    // Attaches a result that is plain to see without running the predictor.
    function automatic dir_row_t row_chk(input dir_row_t r, input int mean, input int filt,
                                         input int dly, input bit frz, input int adapt,
                                         input bit clr);
        r.typed = 1'b1;
        r.res.mean = 16'(mean);
        r.res.filtered = 16'(filt);
        r.res.delay = 8'(dly);
        r.res.freeze = frz;
        r.res.adapted = 16'(adapt);
        r.res.clear = clr;
        return r;
    endfunction

    function automatic dir_row_t row_cfg(input int gain, input int reload, input int thr);
        dir_row_t r;
        r = row_item(1'b0, 1'b0, 1'b0, 1'b0, 0, 0);
        r.kind = ROW_CFG;
        r.gain = 8'(gain);
        r.reload = 8'(reload);
        r.thr = 16'(thr);
        return r;
    endfunction

    // Random item. Noisy items are fully random; the others follow slowly moving request and
    // in-range levels and a drifting feedback band, so that the delay can run out and the
    // latch can actually set.
    function automatic lafz_item_t make_item(input bit noisy);
        lafz_item_t it;
        int         spread;
        if (noisy)
        begin
            it.adapt_request = 1'($urandom_range(1));
            it.monitor_in_range = 1'($urandom_range(1));
            it.max_updated = 1'($urandom_range(1));
            it.min_updated = 1'($urandom_range(1));
            it.feedback_max = 16'($urandom);
            it.feedback_min = 16'($urandom);
            return it;
        end
        if ($urandom_range(req_lvl ? 39 : 3) == 0)
            req_lvl = !req_lvl;
        if ($urandom_range(inr_lvl ? 49 : 3) == 0)
            inr_lvl = !inr_lvl;
        center += int'($urandom_range(64)) - 32;
        if (center > 30000)
            center = 30000;
        if (center < -30000)
            center = -30000;
        spread = $urandom_range(600);
        it.adapt_request = req_lvl;
        it.monitor_in_range = inr_lvl;
        if ($urandom_range(2) == 0)
            {it.max_updated, it.min_updated} = 2'b11;
        else
            {it.max_updated, it.min_updated} = 2'($urandom_range(2));
        it.feedback_max = 16'(center + spread);
        it.feedback_min = 16'(center - spread);
        return it;
    endfunction

    // Offers one item, holds it until taken, then queues the result it should cause.
    // A typed result from the directed table replaces the predicted one; the predictor
    // still advances so that its state stays in step with the block.
    task automatic send_item(input lafz_item_t it, input bit typed, input res_t typed_res);
        res_t want;
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0000, it.feedback_min, it.feedback_max, it.min_updated,
                    it.max_updated, it.monitor_in_range, it.adapt_request};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        want = predict_tick(it);
        pending_results.push_back(typed ? typed_res : want);
    endtask

    // Stops offering items and waits until every queued result has come back.
    // Each item yields exactly one result.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Writes all three registers back to back while the block is idle.
    task automatic write_regs(input logic [7:0] gain, input logic [7:0] reload,
                              input logic [15:0] thr);
        logic [1:0]  idx[3] = '{CFG_FILTER_GAIN, CFG_DELAY_RELOAD, CFG_ERROR_THRESHOLD};
        logic [15:0] vals[3];
        vals[0] = {8'h00, gain};
        vals[1] = {8'h00, reload};
        vals[2] = thr;
        wait_idle();
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
        gain_reg = gain;
        reload_reg = reload;
        thr_reg = thr;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Result side: checks every accepted result against the oldest queued one and drives
    // m_tready with random stall bursts, plus one long hold-off on request.
    initial
    begin : result_sink
        int   stall_left;
        int   hold_left;
        bit   rdy;
        res_t got;
        res_t want;
        stall_left = 0;
        hold_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got = res_t'(m_tdata[57:0]);
                if (pending_results.size() == 0)
                begin
                    $display("%0t ns: result item with none expected, expected nothing, actual %h",
                             $time, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_tdata[63:58] !== 6'b0 || $isunknown(got))
                    begin
                        $display("%0t ns: tdata padding or unknown bits, expected clean, actual %h",
                                 $time, m_tdata);
                        mismatches++;
                    end
                    check_field("mean_out", want.mean, got.mean);
                    check_field("filtered_out", want.filtered, got.filtered);
                    check_field("delay_out", want.delay, got.delay);
                    check_field("freeze_out", want.freeze, got.freeze);
                    check_field("adapted_out", want.adapted, got.adapted);
                    check_field("clear_minmax", want.clear, got.clear);
                end
            end
            // A long hold-off lets the block fill up and push back on its input.
            if (hold_req)
            begin
                hold_left = 60;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rdy = 1'b0;
            end
            else if (!calm && $urandom_range(7) == 0)
            begin
                stall_left = $urandom_range(1, 13) - 1;
                rdy = 1'b0;
            end
            else
                rdy = 1'b1;
            m_tready <= rdy;
        end
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("%0t ns: run did not complete in time", $time);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        logic [7:0]  gain;
        logic [7:0]  reload;
        logic [15:0] thr;
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_FILTER_GAIN;
        cfg_data <= '0;

        // Directed table. Default registers first: the very first item always reseeds the
        // filter, an item without both flags keeps the old mean, and the mean of the two
        // extremes shows truncation toward zero.
        dir_tab.push_back(row_chk(row_item(0, 0, 1, 1, 32767, 32767),
                                  32767, 32767, 50, 0, 0, 0));
        dir_tab.push_back(row_chk(row_item(0, 0, 0, 0, -5, 5), 32767, 32767, 50, 0, 0, 0));
        dir_tab.push_back(row_chk(row_item(0, 0, 1, 1, 32767, -32768), 0, 0, 50, 0, 0, 0));
        // Negative odd sum: mean truncates toward zero while the filter floors.
        dir_tab.push_back(row_item(0, 1, 1, 1, -1, -2));
        dir_tab.push_back(row_item(0, 1, 1, 0, -32768, 32767));
        dir_tab.push_back(row_item(0, 1, 0, 1, 32767, -32768));
        // Request rises, then the monitor leaves its range for two items and comes back.
        dir_tab.push_back(row_item(1, 1, 0, 0, 0, 0));
        dir_tab.push_back(row_item(1, 1, 1, 1, 100, -100));
        dir_tab.push_back(row_item(1, 0, 0, 0, 0, 0));
        dir_tab.push_back(row_item(1, 0, 0, 0, 0, 0));
        dir_tab.push_back(row_item(1, 1, 0, 0, 0, 0));
        // Fastest filter, no delay, widest threshold: the latch sets on the first request.
        dir_tab.push_back(row_cfg(255, 0, 65535));
        dir_tab.push_back(row_item(0, 1, 0, 0, 0, 0));
        dir_tab.push_back(row_chk(row_item(1, 1, 1, 1, 100, 200), 150, 150, 0, 1, 150, 1));
        dir_tab.push_back(row_item(1, 1, 1, 1, 1000, 1000));
        dir_tab.push_back(row_item(1, 1, 1, 1, -32768, -32768));
        dir_tab.push_back(row_item(1, 0, 0, 0, 0, 0));
        dir_tab.push_back(row_item(0, 0, 0, 0, 0, 0));
        // Frozen filter, largest reload (capped at 200), zero threshold.
        dir_tab.push_back(row_cfg(0, 255, 0));
        dir_tab.push_back(row_item(1, 1, 0, 0, 0, 0));
        dir_tab.push_back(row_item(0, 1, 0, 0, 0, 0));
        dir_tab.push_back(row_item(1, 1, 1, 1, 7, 8));
        dir_tab.push_back(row_cfg(GAIN_RESET, RELOAD_RESET, THRESHOLD_RESET));
        dir_tab.push_back(row_item(1, 1, 1, 1, -7, -8));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].kind == ROW_CFG)
                write_regs(dir_tab[i].gain, dir_tab[i].reload, dir_tab[i].thr);
            else
                send_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].res);
        end

        // Random phases, each under its own register setting. The last phase runs with no
        // idling on either side.
        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph % 4)
                0:
                begin
                    gain = 8'd255;
                    reload = 8'd0;
                    thr = 16'hFFFF;
                end
                1:
                begin
                    gain = 8'd0;
                    reload = 8'd255;
                    thr = 16'd0;
                end
                2:
                begin
                    gain = 8'($urandom_range(255));
                    reload = 8'($urandom_range(20));
                    thr = 16'($urandom_range(400));
                end
                default:
                begin
                    gain = 8'($urandom_range(255));
                    reload = 8'($urandom_range(255));
                    thr = 16'($urandom_range(65535));
                end
            endcase
            write_regs(gain, reload, thr);
            calm = (ph == 11);
            req_lvl = 1'($urandom_range(1));
            inr_lvl = 1'($urandom_range(1));
            for (int k = 0; k < 66; k++)
            begin
                if (ph == 3 && k == 10)
                    hold_req = 1'b1;
                // Let the pipeline run completely dry in the middle of a phase.
                if (ph == 5 && k == 30)
                    wait_idle();
                if (!calm && $urandom_range(5) == 0)
                begin
                    s_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 13)) @(posedge clk);
                end
                send_item(make_item($urandom_range(6) == 0), 1'b0, '0);
            end
        end

        wait_idle();
        // Spare cycles at the end catch any stray result.
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/lafz_pkg.sv
hw/rtl/lafz_mean_filter.sv
hw/rtl/lafz_freeze_ctrl.sv
hw/rtl/lambda_adaptation_freeze.sv
test/tb.sv
